@@ hdl/ibook_pkg.sv @@
`default_nettype none

package ibook_pkg;

   // Controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN_DBL,
      ST_SCAN_CNT,
      ST_DECIDE,
      ST_SCAN_ADD,
      ST_RESULT
   } state_type;

   // What the datapath does with each table entry it reads
   typedef enum logic [1:0] {
      MODE_DBL,   // check request against double-booked table
      MODE_CNT,   // count bookings the request overlaps
      MODE_ADD    // store intersections with overlapped bookings
   } mode_type;

   // Response status codes
   typedef enum logic [1:0] {
      STATUS_OK     = 2'd0,
      STATUS_TRIPLE = 2'd1,
      STATUS_FULL   = 2'd2
   } status_type;

   // Controller to datapath
   typedef struct packed {
      logic     load;        // capture the request interval, clear flags
      logic     start;       // rewind the scan index
      logic     scan;        // step the scan while entries remain
      logic     book_write;  // append the request to the booking table
      mode_type mode;
   } dp_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic scan_done;
      logic triple;
      logic full;
   } dp_stat_type;

endpackage

`default_nettype wire

@@ hdl/ibook_dp.sv @@
`default_nettype none

module ibook_dp
   import ibook_pkg::*;
#(
   parameter int MAX_BOOKINGS = 64,
   parameter int MAX_DOUBLES  = 128,
   parameter int TIME_BITS    = 32
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic [TIME_BITS-1:0] req_start_time,
   input  wire logic [TIME_BITS-1:0] req_end_time,
   input  wire dp_cmd_type           cmd,
   output dp_stat_type               stat
);

   localparam int BC_W  = $clog2(MAX_BOOKINGS + 1);
   localparam int DC_W  = $clog2(MAX_DOUBLES + 1);
   localparam int BA_W  = $clog2(MAX_BOOKINGS);
   localparam int DA_W  = $clog2(MAX_DOUBLES);
   localparam int IDX_W = (BC_W > DC_W) ? BC_W : DC_W;
   localparam int CMP_W = IDX_W + 1;
   localparam int ENT_W = 2 * TIME_BITS;

   // Tables: {start, end} per entry
   logic [ENT_W-1:0] bk_mem [MAX_BOOKINGS];
   logic [ENT_W-1:0] db_mem [MAX_DOUBLES];

   logic [ENT_W-1:0]     bk_rd_ff;
   logic [ENT_W-1:0]     db_rd_ff;
   logic [TIME_BITS-1:0] lo_ff;
   logic [TIME_BITS-1:0] hi_ff;
   logic [BC_W-1:0]      bc_ff;
   logic [BC_W-1:0]      bc_in;
   logic [DC_W-1:0]      dc_ff;
   logic [DC_W-1:0]      dc_in;
   logic [IDX_W-1:0]     idx_ff;
   logic [IDX_W-1:0]     idx_in;
   logic                 chk_ff;
   logic                 chk_in;
   logic                 triple_ff;
   logic                 triple_in;
   logic [BC_W-1:0]      added_ff;
   logic [BC_W-1:0]      added_in;

   logic [IDX_W-1:0]     limit;
   logic                 issue;
   logic [ENT_W-1:0]     ent;
   logic [TIME_BITS-1:0] ent_lo;
   logic [TIME_BITS-1:0] ent_hi;
   logic                 meet;
   logic                 db_we;
   logic [TIME_BITS-1:0] isect_lo;
   logic [TIME_BITS-1:0] isect_hi;

   // Scan sequencing: one read issued per cycle, checked the cycle after
   assign limit = (cmd.mode == MODE_DBL) ? IDX_W'(dc_ff) : IDX_W'(bc_ff);
   assign issue = cmd.scan && (idx_ff < limit);

   always_comb begin
      idx_in = idx_ff;
      chk_in = issue;
      if (cmd.start) begin
         idx_in = '0;
         chk_in = 1'b0;
      end else if (issue) begin
         idx_in = idx_ff + IDX_W'(1);
      end
   end

   // Overlap test against the entry read last cycle
   assign ent    = (cmd.mode == MODE_DBL) ? db_rd_ff : bk_rd_ff;
   assign ent_lo = ent[ENT_W-1:TIME_BITS];
   assign ent_hi = ent[TIME_BITS-1:0];
   assign meet   = (lo_ff < ent_hi) && (ent_lo < hi_ff);

   assign isect_lo = (lo_ff > ent_lo) ? lo_ff : ent_lo;
   assign isect_hi = (hi_ff < ent_hi) ? hi_ff : ent_hi;
   assign db_we    = chk_ff && (cmd.mode == MODE_ADD) && meet;

   // Flags and counts
   always_comb begin
      triple_in = triple_ff;
      added_in  = added_ff;
      dc_in     = dc_ff;
      bc_in     = bc_ff;
      if (cmd.load) begin
         triple_in = 1'b0;
         added_in  = '0;
      end else if (chk_ff && meet) begin
         if (cmd.mode == MODE_DBL) begin
            triple_in = 1'b1;
         end else if (cmd.mode == MODE_CNT) begin
            added_in = added_ff + BC_W'(1);
         end
      end
      if (db_we) begin
         dc_in = dc_ff + DC_W'(1);
      end
      if (cmd.book_write) begin
         bc_in = bc_ff + BC_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bc_ff     <= '0;
         dc_ff     <= '0;
         idx_ff    <= '0;
         chk_ff    <= 1'b0;
         triple_ff <= 1'b0;
         added_ff  <= '0;
      end else begin
         bc_ff     <= bc_in;
         dc_ff     <= dc_in;
         idx_ff    <= idx_in;
         chk_ff    <= chk_in;
         triple_ff <= triple_in;
         added_ff  <= added_in;
      end
   end

   // Request interval capture
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         lo_ff <= req_start_time;
         hi_ff <= req_end_time;
      end
   end

   // Booking table
   always_ff @(posedge clock) begin
      if (cmd.book_write) begin
         bk_mem[bc_ff[BA_W-1:0]] <= {lo_ff, hi_ff};
      end
      if (issue) begin
         bk_rd_ff <= bk_mem[idx_ff[BA_W-1:0]];
      end
   end

   // Double-booked table
   always_ff @(posedge clock) begin
      if (db_we) begin
         db_mem[dc_ff[DA_W-1:0]] <= {isect_lo, isect_hi};
      end
      if (issue) begin
         db_rd_ff <= db_mem[idx_ff[DA_W-1:0]];
      end
   end

   // Status back to the controller
   assign stat.scan_done = !issue && !chk_ff;
   assign stat.triple    = triple_ff;
   assign stat.full      = (bc_ff == BC_W'(MAX_BOOKINGS)) ||
                           (CMP_W'(added_ff) > (CMP_W'(MAX_DOUBLES) - CMP_W'(dc_ff)));

endmodule

`default_nettype wire

@@ hdl/ibook_ctrl.sv @@
`default_nettype none

module ibook_ctrl
   import ibook_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_status,
   output dp_cmd_type       cmd,
   input  wire dp_stat_type stat
);

   state_type  state_ff;
   state_type  state_in;
   status_type stat_ff;
   status_type stat_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   status_type rsp_status_ff;
   logic       out_load;

   // State register and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      stat_ff <= stat_in;
      if (out_load) begin
         rsp_status_ff <= stat_ff;
      end
   end

   // Next state and datapath commands
   always_comb begin
      state_in       = state_ff;
      stat_in        = stat_ff;
      out_load       = 1'b0;
      cmd.load       = 1'b0;
      cmd.start      = 1'b0;
      cmd.scan       = 1'b0;
      cmd.book_write = 1'b0;
      cmd.mode       = MODE_DBL;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load  = 1'b1;
               cmd.start = 1'b1;
               state_in  = ST_SCAN_DBL;
            end
         end
         ST_SCAN_DBL: begin
            cmd.mode = MODE_DBL;
            cmd.scan = 1'b1;
            if (stat.scan_done) begin
               cmd.start = 1'b1;
               state_in  = ST_SCAN_CNT;
            end
         end
         ST_SCAN_CNT: begin
            cmd.mode = MODE_CNT;
            cmd.scan = 1'b1;
            if (stat.scan_done) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (stat.triple) begin
               stat_in  = STATUS_TRIPLE;
               state_in = ST_RESULT;
            end else if (stat.full) begin
               stat_in  = STATUS_FULL;
               state_in = ST_RESULT;
            end else begin
               cmd.start = 1'b1;
               state_in  = ST_SCAN_ADD;
            end
         end
         ST_SCAN_ADD: begin
            cmd.mode = MODE_ADD;
            cmd.scan = 1'b1;
            if (stat.scan_done) begin
               cmd.book_write = 1'b1;
               stat_in        = STATUS_OK;
               state_in       = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Response handshake
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign req_stall  = (state_ff != ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;

endmodule

`default_nettype wire

@@ hdl/interval_booking_no_triple_overlap_core.sv @@
`default_nettype none

// Interval booking without triple overlap. Each request carries a half-open
// interval [start, end) (low TIME_BITS bits used) and gets one response:
// 0 accepted, 1 rejected because it would triple-book, 2 rejected because the
// booking or double-booked table would overflow (nothing changes then). An
// accepted request stores itself and its intersections with every booking
// it overlaps. Requests are handled one at a time; a response may wait in
// its output register while the next request is taken. Each request scans
// the single read port of each table one entry per cycle: the double table
// once, then the booking table to count overlaps and, if accepted, again to
// store them. A rejected request skips the store scan, and a response still
// stalled in the output register holds back the next result until taken.
module interval_booking_no_triple_overlap_core
   import ibook_pkg::*;
#(
   parameter int MAX_BOOKINGS = 64,
   parameter int MAX_DOUBLES  = 128,
   parameter int TIME_BITS    = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [31:0] req_start_time,
   input  wire logic [31:0] req_end_time,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_status
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   // Sequencer
   ibook_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_status (rsp_status),
      .cmd        (cmd),
      .stat       (stat)
   );

   // Tables and overlap logic
   ibook_dp #(
      .MAX_BOOKINGS (MAX_BOOKINGS),
      .MAX_DOUBLES  (MAX_DOUBLES),
      .TIME_BITS    (TIME_BITS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .req_start_time (req_start_time[TIME_BITS-1:0]),
      .req_end_time   (req_end_time[TIME_BITS-1:0]),
      .cmd            (cmd),
      .stat           (stat)
   );

endmodule

`default_nettype wire
